>>> sv/cmtm_pkg.sv
// Shared types and constants of the CAN message timeout monitor.
`default_nettype none
package cmtm_pkg;

  localparam int NUM_ENTRIES  = 64;
  localparam int TIMEOUT_BITS = 16;

  localparam int IDX_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(NUM_ENTRIES + 1);
  localparam int ID_W    = 29;
  localparam int COUNT_W = TIMEOUT_BITS + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] OP_FRAME   = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_PROGRAM = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [28:0] frame_id;
    logic        is_extended;
    logic        is_error_frame;
    logic [5:0]  entry_index;
    logic [28:0] watch_id;
    logic [15:0] entry_timeout;
  } item_t;

  typedef struct packed {
    logic [63:0] timeout_flags;
    logic        any_timeout;
    logic        frame_matched;
  } result_t;

  // one word of the watch table memory
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic [TIMEOUT_BITS-1:0] limit;
    logic [COUNT_W-1:0]      count;
  } entry_t;

  typedef struct packed {
    logic             accept;
    logic             busy;
    logic             done;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wb_en;
    logic [IDX_W-1:0] wb_addr;
  } ctl_t;

endpackage
`default_nettype wire

>>> sv/cmtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cmtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> sv/cmtm_ctrl.sv
// Sequencer: takes a transaction and, when a sweep is requested, sweeps the watch table read-modify-write.
`default_nettype none
module cmtm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          sweep_req_i,
  output      cmtm_pkg::ctl_t ctl_o
);
  import cmtm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_DONE  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wb_v_q, wb_v_d;
  logic [IDX_W-1:0] wb_addr_q, wb_addr_d;
  logic             rd_more;

  assign rd_more = (cnt_q < CNT_W'(NUM_ENTRIES));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    wb_v_d    = 1'b0;
    wb_addr_d = wb_addr_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cnt_d   = '0;
          state_d = sweep_req_i ? S_SWEEP : S_DONE;
        end
      end
      S_SWEEP: begin
        // read entry cnt now, write it back next cycle
        if (rd_more) begin
          wb_v_d    = 1'b1;
          wb_addr_d = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + 1'b1;
        end else if (!wb_v_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      wb_v_q    <= 1'b0;
      wb_addr_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      wb_v_q    <= wb_v_d;
      wb_addr_q <= wb_addr_d;
    end
  end

  always_comb begin
    ctl_o.accept  = start_i && (state_q == S_IDLE);
    ctl_o.busy    = (state_q != S_IDLE);
    ctl_o.done    = (state_q == S_DONE);
    ctl_o.rd_en   = (state_q == S_SWEEP) && rd_more;
    ctl_o.rd_addr = cnt_q[IDX_W-1:0];
    ctl_o.wb_en   = wb_v_q;
    ctl_o.wb_addr = wb_addr_q;
  end

endmodule
`default_nettype wire

>>> sv/can_message_timeout_monitor_top.sv
// CAN message timeout monitor: top level with watch table datapath.
//
// Usage: present a transaction on item_i and raise start_i; it is taken at a
// rising edge where start_i is high and busy_o is low. Each transaction gives
// one result on result_o, marked by result_valid_o for exactly one cycle; the
// receiver cannot hold it off.
// Program items, unused operation codes and frames that are standard or error
// frames go from idle straight to the done state, with no table walk.
// Ticks and received extended frames that are not error frames walk the whole
// watch table through the single-port-pair entry memory, one entry per cycle,
// then finish the last write-back before the done state shows the result.
// busy_o stays high through the result cycle, so one item is in flight at a
// time; the next can be taken once the sequencer is back in idle after the
// result.
// The read of entry k+1 overlaps the write-back of entry k, so the same entry
// is never read and written in one cycle.
// Reset clears every valid bit and timeout flag and returns the sequencer to
// idle; the table memory needs no clearing pass, since the data read from an
// entry is used only once a program item has written it and set its valid bit.
`default_nettype none
module can_message_timeout_monitor_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output      logic              busy_o,
  input  wire cmtm_pkg::item_t   item_i,
  output      logic              result_valid_o,
  output      cmtm_pkg::result_t result_o
);
  import cmtm_pkg::*;

  ctl_t                    ctl;
  logic                    sweep_req;
  logic                    is_tick_q;
  logic [ID_W-1:0]         fid_q;
  logic                    matched_q;
  logic [NUM_ENTRIES-1:0]  valid_q;
  logic [NUM_ENTRIES-1:0]  flags_q;

  entry_t                  rd_ent;
  entry_t                  wr_ent;
  logic [COUNT_W-1:0]      cnt_inc;
  logic                    over;
  logic                    wb_live;
  logic                    refresh;
  logic                    bump;
  logic                    prog_we;
  logic [IDX_W-1:0]        prog_idx;
  logic [31:0]             lim_wide;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [$bits(entry_t)-1:0] ram_rdata;

  assign sweep_req = (item_i.operation == OP_TICK) ||
                     ((item_i.operation == OP_FRAME) && item_i.is_extended &&
                      !item_i.is_error_frame);

  cmtm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .sweep_req_i (sweep_req),
    .ctl_o       (ctl)
  );

  // program write lands at the accepting edge
  assign prog_idx = item_i.entry_index[IDX_W-1:0];
  assign prog_we  = ctl.accept && (item_i.operation == OP_PROGRAM) &&
                    (7'(item_i.entry_index) < 7'(NUM_ENTRIES));
  assign lim_wide = 32'(item_i.entry_timeout);

  assign rd_ent  = entry_t'(ram_rdata);
  assign cnt_inc = (rd_ent.count == COUNT_MAX) ? rd_ent.count : rd_ent.count + 1'b1;
  assign over    = (cnt_inc > {1'b0, rd_ent.limit});
  assign wb_live = ctl.wb_en && valid_q[ctl.wb_addr];
  assign refresh = wb_live && !is_tick_q && (rd_ent.id == fid_q);
  assign bump    = wb_live && is_tick_q;

  always_comb begin
    wr_ent    = rd_ent;
    ram_waddr = ctl.wb_addr;
    if (prog_we) begin
      wr_ent.id    = item_i.watch_id;
      wr_ent.limit = lim_wide[TIMEOUT_BITS-1:0];
      wr_ent.count = '0;
      ram_waddr    = prog_idx;
    end else if (bump) begin
      wr_ent.count = cnt_inc;
    end else begin
      wr_ent.count = '0;
    end
  end

  assign ram_we = prog_we || refresh || bump;

  cmtm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_ent),
    .re_i    (ctl.rd_en),
    .raddr_i (ctl.rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      is_tick_q <= (item_i.operation == OP_TICK);
      fid_q     <= item_i.frame_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= 1'b0;
      valid_q   <= '0;
      flags_q   <= '0;
    end else begin
      if (ctl.accept) begin
        matched_q <= 1'b0;
      end
      if (prog_we) begin
        valid_q[prog_idx] <= 1'b1;
        flags_q[prog_idx] <= 1'b0;
      end
      if (refresh) begin
        flags_q[ctl.wb_addr] <= 1'b0;
        matched_q            <= 1'b1;
      end
      if (bump && over) begin
        flags_q[ctl.wb_addr] <= 1'b1;
      end
    end
  end

  // flags are only ever set on valid entries
  always_comb begin
    result_o.timeout_flags = 64'(flags_q);
    result_o.any_timeout   = |flags_q;
    result_o.frame_matched = matched_q;
  end

  assign result_valid_o = ctl.done;
  assign busy_o         = ctl.busy;

endmodule
`default_nettype wire

>>> sv/cmtm_checker.sv
// Port-level checker for the timeout monitor, bound to the top level.
`default_nettype none
module cmtm_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire cmtm_pkg::item_t   item_i,
  input wire logic              result_valid_o,
  input wire cmtm_pkg::result_t result_o
);
  import cmtm_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  // a transaction always occupies the block until its result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result shown while idle");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_any_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.any_timeout == (result_o.timeout_flags != '0)))
    else $error("any_timeout disagrees with flag bitmap");

  a_match_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.operation != OP_FRAME) |=> !result_o.frame_matched)
    else $error("frame_matched set for a non-frame transaction");

endmodule

bind can_message_timeout_monitor_top cmtm_checker u_cmtm_checker (.*);
`default_nettype wire

>>> test/tb_can_message_timeout_monitor_top.sv
// Self-checking testbench of the CAN message timeout monitor top level.
`default_nettype none
module tb_can_message_timeout_monitor_top;
  import cmtm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    item_t item;
    int    idle_pct;
    bit    drain_first;
  } txn_t;

  logic    clk_i;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  item_t   item_i = '0;
  logic    busy_o;
  logic    result_valid_o;
  result_t result_o;

  txn_t    txn_q[$];
  result_t flags_q[$];
  result_t want;
  int      err_cnt = 0;

  // shadow watch table
  logic                    wt_valid [NUM_ENTRIES];
  logic [ID_W-1:0]         wt_id    [NUM_ENTRIES];
  logic [TIMEOUT_BITS-1:0] wt_limit [NUM_ENTRIES];
  logic [COUNT_W-1:0]      wt_count [NUM_ENTRIES];
  logic                    wt_tout  [NUM_ENTRIES];

  can_message_timeout_monitor_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic result_t step_watch_table(item_t it);
    result_t r;
    r = '0;
    case (it.operation)
      OP_FRAME: begin
        if (it.is_extended && !it.is_error_frame) begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (wt_valid[i] && wt_id[i] == it.frame_id) begin
              wt_count[i] = '0;
              wt_tout[i] = 1'b0;
              r.frame_matched = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (wt_valid[i]) begin
            if (wt_count[i] != COUNT_MAX) wt_count[i] = wt_count[i] + 1'b1;
            if (wt_count[i] > {1'b0, wt_limit[i]}) wt_tout[i] = 1'b1;
          end
        end
      end
      OP_PROGRAM: begin
        if (int'(it.entry_index) < NUM_ENTRIES) begin
          wt_valid[it.entry_index] = 1'b1;
          wt_id[it.entry_index]    = it.watch_id;
          wt_limit[it.entry_index] = it.entry_timeout;
          wt_count[it.entry_index] = '0;
          wt_tout[it.entry_index]  = 1'b0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_ENTRIES; i++) r.timeout_flags[i] = wt_valid[i] && wt_tout[i];
    r.any_timeout = |r.timeout_flags;
    return r;
  endfunction

  function automatic item_t make_item(logic [1:0] op, logic [28:0] fid, logic ext,
                                      logic err, logic [5:0] idx, logic [28:0] wid,
                                      logic [15:0] lim);
    item_t it;
    it.operation      = op;
    it.frame_id       = fid;
    it.is_extended    = ext;
    it.is_error_frame = err;
    it.entry_index    = idx;
    it.watch_id       = wid;
    it.entry_timeout  = lim;
    return it;
  endfunction

  task automatic queue_txn(item_t it, int idle_pct, bit drain_first);
    txn_t t;
    t.item        = it;
    t.idle_pct    = idle_pct;
    t.drain_first = drain_first;
    txn_q.insert(txn_q.size(), t);
  endtask

  // driver: head of txn_q stays on the bus until the block takes it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      item_i  <= '0;
    end else begin
      if (start_i && !busy_o) void'(txn_q.pop_front());
      if (start_i && busy_o) begin
        // keep presenting
      end else if (txn_q.size() != 0 &&
                   !(txn_q[0].drain_first && (start_i || flags_q.size() != 0)) &&
                   $urandom_range(99) >= txn_q[0].idle_pct) begin
        start_i <= 1'b1;
        item_i  <= txn_q[0].item;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: predict on every accepted transaction, check every result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        wt_valid[i] = 1'b0;
        wt_id[i]    = '0;
        wt_limit[i] = '0;
        wt_count[i] = '0;
        wt_tout[i]  = 1'b0;
      end
    end else begin
      if (result_valid_o) begin
        if (flags_q.size() == 0) begin
          $error("result with no transaction outstanding: %h", result_o);
          err_cnt = err_cnt + 1;
        end else begin
          want = flags_q.pop_front();
          if (result_o.timeout_flags !== want.timeout_flags) begin
            $error("timeout_flags: expected %h, got %h", want.timeout_flags,
                   result_o.timeout_flags);
            err_cnt = err_cnt + 1;
          end
          if (result_o.any_timeout !== want.any_timeout) begin
            $error("any_timeout: expected %b, got %b", want.any_timeout,
                   result_o.any_timeout);
            err_cnt = err_cnt + 1;
          end
          if (result_o.frame_matched !== want.frame_matched) begin
            $error("frame_matched: expected %b, got %b", want.frame_matched,
                   result_o.frame_matched);
            err_cnt = err_cnt + 1;
          end
        end
      end
      if (start_i && !busy_o) flags_q.insert(flags_q.size(), step_watch_table(item_i));
    end
  end

  initial begin
    #(8 * 400_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [28:0] id_pool [6];
    item_t       it;
    int          idle_pct;
    int          sel;
    bit          drain_first;

    id_pool[0] = '0;
    id_pool[1] = 29'h1FFF_FFFF;
    for (int i = 2; i < 6; i++) id_pool[i] = 29'($urandom);

    // directed part, no idling
    queue_txn(make_item(OP_FRAME, '0, 1'b1, 1'b0, '0, '0, '0), 0, 1'b0);   // all slots invalid
    queue_txn(make_item(OP_TICK, '0, 1'b0, 1'b0, '0, '0, '0), 0, 1'b0);
    queue_txn(make_item(OP_UNUSED, '1, 1'b1, 1'b1, '1, '1, '1), 0, 1'b0);
    queue_txn(make_item(OP_PROGRAM, '1, 1'b1, 1'b1, 6'd0, '0, 16'd0), 0, 1'b0);
    queue_txn(make_item(OP_PROGRAM, '0, 1'b0, 1'b0, 6'd63, '1, 16'hFFFF), 0, 1'b0);
    queue_txn(make_item(OP_PROGRAM, '0, 1'b0, 1'b0, 6'd1, '1, 16'd1), 0, 1'b0);  // dup id
    queue_txn(make_item(OP_TICK, '1, 1'b1, 1'b0, '1, '1, '1), 0, 1'b0);
    queue_txn(make_item(OP_TICK, '0, 1'b0, 1'b0, '0, '0, '0), 0, 1'b0);
    queue_txn(make_item(OP_UNUSED, '0, 1'b0, 1'b0, '0, '0, '0), 0, 1'b0);
    queue_txn(make_item(OP_FRAME, '1, 1'b0, 1'b0, '0, '0, '0), 0, 1'b0);   // standard frame
    queue_txn(make_item(OP_FRAME, '1, 1'b1, 1'b1, '0, '0, '0), 0, 1'b0);   // error frame
    queue_txn(make_item(OP_FRAME, '1, 1'b1, 1'b0, '0, '0, '0), 0, 1'b0);   // refreshes 1 and 63
    queue_txn(make_item(OP_FRAME, 29'h1234_5678, 1'b1, 1'b0, '0, '0, '0), 0, 1'b0);
    queue_txn(make_item(OP_TICK, '0, 1'b0, 1'b0, '0, '0, '0), 0, 1'b0);
    queue_txn(make_item(OP_TICK, '0, 1'b0, 1'b0, '0, '0, '0), 0, 1'b0);
    // reprogram a timed-out slot
    queue_txn(make_item(OP_PROGRAM, '0, 1'b0, 1'b0, 6'd0, 29'h0AAA_AAAA, 16'd2), 0, 1'b0);
    queue_txn(make_item(OP_FRAME, '0, 1'b1, 1'b0, '0, '0, '0), 0, 1'b0);
    for (int k = 0; k < 4; k++)
      queue_txn(make_item(OP_TICK, '0, 1'b0, 1'b0, '0, '0, '0), 0, 1'b0);
    queue_txn(make_item(OP_FRAME, 29'h0AAA_AAAA, 1'b1, 1'b0, '1, '1, '1), 0, 1'b0);

    // random part in three idle phases
    for (int n = 0; n < 450; n++) begin
      idle_pct = (n < 150) ? 30 : (n < 300) ? 65 : 0;
      it.operation      = 2'($urandom);
      it.frame_id       = 29'($urandom);
      it.is_extended    = 1'($urandom);
      it.is_error_frame = 1'($urandom);
      it.entry_index    = 6'($urandom);
      it.watch_id       = 29'($urandom);
      it.entry_timeout  = 16'($urandom);
      sel = $urandom_range(99);
      if (sel < 20) begin
        it.operation = OP_PROGRAM;
        if ($urandom_range(9) != 0) it.watch_id = id_pool[$urandom_range(5)];
        sel = $urandom_range(9);
        if (sel < 8) it.entry_timeout = 16'($urandom_range(6));
        else if (sel == 8) it.entry_timeout = $urandom_range(1) ? 16'hFFFF : 16'd0;
      end else if (sel < 55) begin
        it.operation = OP_TICK;
      end else if (sel < 92) begin
        it.operation = OP_FRAME;
        if ($urandom_range(9) != 0) begin
          it.is_extended    = 1'b1;
          it.is_error_frame = 1'b0;
          if ($urandom_range(7) != 0) it.frame_id = id_pool[$urandom_range(5)];
        end
      end
      drain_first = (n % 150 == 0) || ($urandom_range(49) == 0);
      queue_txn(it, idle_pct, drain_first);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (txn_q.size() != 0 || flags_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (flags_q.size() != 0) begin
      $error("%0d results never arrived", flags_q.size());
      err_cnt = err_cnt + 1;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
